// ===== sv/assert_macros.svh =====
// Assertion macros for the checker module of the image receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== sv/sir_pkg.sv =====
// Types and constants shared by the sequenced image receiver modules.
package sir_pkg;

    localparam int LEN_W   = 19;
    localparam int ADDR_W  = 18;
    localparam int FRAME_W = 16;
    localparam int SUM_W   = 32;
    localparam int TYPE_W  = 8;

    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};

    // Configuration register indexes.
    localparam logic CFG_IMAGE_LENGTH  = 1'b0;
    localparam logic CFG_TRANSFER_TYPE = 1'b1;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_CHECK = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INACTIVE     = 3'd1,
        ST_FRAME_AHEAD  = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_LEN_MISMATCH = 3'd4,
        ST_SUM_MISMATCH = 3'd5,
        ST_TOO_LONG     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        V_UNCHECKED = 2'd0,
        V_SEQUENCED = 2'd1,
        V_DUPLICATE = 2'd2,
        V_AHEAD     = 2'd3
    } t_verdict;

    typedef struct packed {
        logic               armed;
        logic [LEN_W-1:0]   byte_count;
        logic [FRAME_W-1:0] frame_count;
        logic [SUM_W-1:0]   byte_sum;
        logic               inside_frame;
        t_verdict           verdict;
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [7:0]         data_byte;
        logic [FRAME_W-1:0] frame_number;
        logic               last_in_frame;
        logic               sequenced;
        logic [SUM_W-1:0]   expected_checksum;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [7:0]         write_data;
        logic               active;
        logic [SUM_W-1:0]   computed_sum;
    } t_result;

endpackage

// ===== sv/sir_step.sv =====
// Next-state and result logic for one item of the image receiver.
module sir_step import sir_pkg::*; #(
    parameter int unsigned MAX_IMAGE_BYTES = 262144
) (
    input  t_state            i_state,
    input  t_item             i_item,
    input  logic [LEN_W-1:0]  i_image_length,
    input  logic [TYPE_W-1:0] i_transfer_type,
    output t_state            o_state,
    output t_result           o_result
);

    logic     too_long;
    logic     at_limit;
    logic     count_sat;
    t_verdict verdict;

    // Length against the build-time maximum, and the overflow limit.
    assign too_long  = 32'(i_image_length) > 32'(MAX_IMAGE_BYTES);
    assign at_limit  = (i_state.byte_count >= i_image_length) ||
                       (32'(i_state.byte_count) >= 32'(MAX_IMAGE_BYTES));
    assign count_sat = (i_state.byte_count == COUNT_MAX);

    // The first byte of a frame decides the verdict for the whole frame.
    always_comb begin
        if (i_state.inside_frame) begin
            verdict = i_state.verdict;
        end else if (!i_item.sequenced) begin
            verdict = V_UNCHECKED;
        end else if (i_item.frame_number == i_state.frame_count) begin
            verdict = V_SEQUENCED;
        end else if (i_item.frame_number < i_state.frame_count) begin
            verdict = V_DUPLICATE;
        end else begin
            verdict = V_AHEAD;
        end
    end

    // Operation decode and state update.
    always_comb begin
        o_state                = i_state;
        o_result               = '0;
        o_result.status        = ST_OK;
        case (i_item.op)
            OP_START: begin
                if (too_long) begin
                    o_result.status = ST_TOO_LONG;
                end else begin
                    o_state.byte_count   = '0;
                    o_state.byte_sum     = '0;
                    o_state.inside_frame = 1'b0;
                    o_state.verdict      = V_UNCHECKED;
                    o_state.armed        = (i_transfer_type != '0);
                end
            end
            OP_DATA: begin
                o_state.inside_frame = !i_item.last_in_frame;
                if (!i_state.armed) begin
                    o_result.status = ST_INACTIVE;
                end else begin
                    o_state.verdict = verdict;
                    if (verdict == V_AHEAD) begin
                        o_result.status = ST_FRAME_AHEAD;
                    end else if (verdict == V_DUPLICATE) begin
                        o_result.status = ST_OK;
                    end else if (at_limit) begin
                        // Overflow: the byte is dropped and the transfer cancelled.
                        if (!count_sat) begin
                            o_state.byte_count = i_state.byte_count + 1'b1;
                        end
                        o_state.armed   = 1'b0;
                        o_result.status = ST_OVERFLOW;
                        if (verdict == V_SEQUENCED) begin
                            o_state.frame_count = '0;
                        end
                    end else begin
                        o_result.write_enable  = 1'b1;
                        o_result.write_address = i_state.byte_count[ADDR_W-1:0];
                        o_result.write_data    = i_item.data_byte;
                        o_state.byte_sum       = i_state.byte_sum +
                                                 SUM_W'(i_item.data_byte);
                        if (!count_sat) begin
                            o_state.byte_count = i_state.byte_count + 1'b1;
                        end
                        if (i_item.last_in_frame && (verdict == V_SEQUENCED)) begin
                            o_state.frame_count = i_state.frame_count + 1'b1;
                        end
                    end
                end
            end
            OP_CHECK: begin
                if (i_state.byte_count != i_image_length) begin
                    o_state.armed   = 1'b0;
                    o_result.status = ST_LEN_MISMATCH;
                end else if (!i_state.armed) begin
                    o_result.status = ST_INACTIVE;
                end else if (i_item.expected_checksum != i_state.byte_sum) begin
                    o_state.armed   = 1'b0;
                    o_result.status = ST_SUM_MISMATCH;
                end
            end
            default: begin
                // End returns the transfer state to its reset value.
                o_state = '0;
            end
        endcase
        o_result.active       = o_state.armed;
        o_result.computed_sum = o_state.byte_sum;
    end

endmodule

// ===== sv/sequenced_image_receiver_core.sv =====
// Top level of the sequenced image receiver: item register, step logic, result register.
// The receiver takes one item per clock cycle when the output side does not stall. Each
// item is captured in the item register and its result in the result register, which
// drives the outputs. The rate is set by the transfer state (count, frame number, running
// sum), which is read and updated once per item by a single pass of compare, increment and
// add between the item register and the result register. A stall on the output holds the
// result register, and the input stalls only when both the item register and the result
// register are occupied and the output stalls.
module sequenced_image_receiver_core import sir_pkg::*; #(
    parameter int unsigned MAX_IMAGE_BYTES = 262144
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port.
    input  logic               i_cfg_write_enable,
    input  logic               i_cfg_index,
    input  logic [LEN_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_data_byte,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  logic               i_last_in_frame,
    input  logic               i_sequenced,
    input  logic [SUM_W-1:0]   i_expected_checksum,
    // Output channel.
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic               o_write_enable,
    output logic [ADDR_W-1:0]  o_write_address,
    output logic [7:0]         o_write_data,
    output logic               o_active,
    output logic [SUM_W-1:0]   o_computed_sum
);

    logic [LEN_W-1:0]  r_image_length;
    logic [TYPE_W-1:0] r_transfer_type;
    logic              r_item_valid;
    t_item             r_item;
    logic              r_res_valid;
    t_result           r_result;
    t_state            r_state;
    t_state            n_state;
    t_result           n_result;
    logic              advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_length  <= '0;
            r_transfer_type <= '0;
        end else if (i_cfg_write_enable) begin
            case (i_cfg_index)
                CFG_IMAGE_LENGTH:  r_image_length  <= i_cfg_data;
                CFG_TRANSFER_TYPE: r_transfer_type <= i_cfg_data[TYPE_W-1:0];
                default:           r_image_length  <= r_image_length;
            endcase
        end
    end

    // Handshake: an item moves on when the result register is free or being drained.
    assign advance    = r_item_valid && (!r_res_valid || !i_out_stall);
    assign o_in_stall = r_item_valid && r_res_valid && i_out_stall;

    // Item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.op                <= t_op'(i_operation);
            r_item.data_byte         <= i_data_byte;
            r_item.frame_number      <= i_frame_number;
            r_item.last_in_frame     <= i_last_in_frame;
            r_item.sequenced         <= i_sequenced;
            r_item.expected_checksum <= i_expected_checksum;
        end
    end

    // Per-item logic.
    sir_step #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_step (
        .i_state         (r_state),
        .i_item          (r_item),
        .i_image_length  (r_image_length),
        .i_transfer_type (r_transfer_type),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // Transfer state commits when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_res_valid;
    assign o_status        = r_result.status;
    assign o_write_enable  = r_result.write_enable;
    assign o_write_address = r_result.write_address;
    assign o_write_data    = r_result.write_data;
    assign o_active        = r_result.active;
    assign o_computed_sum  = r_result.computed_sum;

endmodule

// ===== sv/sir_checker.sv =====
// Port-level checker for the sequenced image receiver, bound to the top level.
`include "assert_macros.svh"

module sir_checker import sir_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic               o_write_enable,
    input logic [ADDR_W-1:0]  o_write_address,
    input logic [7:0]         o_write_data,
    input logic               o_active,
    input logic [SUM_W-1:0]   o_computed_sum
);

    // A stalled result stays offered with its status and computed sum unchanged.
    `SIR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_computed_sum) && $stable(o_status))

    // A stored byte is always reported with an ok status and a live transfer.
    `SIR_ASSERT_IMPLY(a_write_ok, i_clk, i_rst_n, o_out_valid && o_write_enable, (o_status == ST_OK) && o_active)

    // Cancelling outcomes leave the transfer inactive.
    `SIR_ASSERT_IMPLY(a_cancel_inactive, i_clk, i_rst_n, o_out_valid && ((o_status == ST_OVERFLOW) || (o_status == ST_LEN_MISMATCH) || (o_status == ST_SUM_MISMATCH)), !o_active)

    // Without a write the address and data lines read zero.
    `SIR_ASSERT_IMPLY(a_idle_write_zero, i_clk, i_rst_n, o_out_valid && !o_write_enable, (o_write_address == '0) && (o_write_data == '0))

endmodule

bind sequenced_image_receiver_core sir_checker u_sir_checker (.*);
